/* sv/ttps_pkg.sv */
// Package for the timed tone prescale select block: payload structs, request codes,
// sequencer states and divider sizing. No dependencies.
`timescale 1ns / 1ps

package ttps_pkg;

	// Core clock rate that the tone timer divides down.
	localparam int CLOCK_HZ = 16000000;

	// Width of the quotient CLOCK_HZ / (2 * freq) and of the serial dividend.
	localparam int QUO_W = $clog2(CLOCK_HZ + 1);
	// The divisor is twice a 16-bit frequency.
	localparam int DVS_W = 17;
	// Step counter of the serial divider.
	localparam int CNT_W = $clog2(QUO_W + 1);

	localparam logic [QUO_W-1:0] CLOCK_VAL = QUO_W'(CLOCK_HZ);

	// Prescale divisors 1, 8, 32, 64, 128, 256 and 1024 are powers of two.
	localparam int NUM_DIV = 7;

	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_STOP  = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;

	localparam logic [2:0] CODE_OFF     = 3'd0;
	localparam logic [2:0] CODE_SLOWEST = 3'd7;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] freq_hz;
		logic [15:0] tone_ms;
	} ttps_req_t;

	typedef struct packed {
		logic       sounding;
		logic [2:0] prescale_code;
		logic [7:0] compare_value;
	} ttps_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_WRITE
	} ttps_state_t;

	// Log2 of the prescale divisor at position k of the search order.
	function automatic logic [3:0] div_shift(input logic [2:0] k);
		logic [3:0] s;
		case (k)
			3'd0:    s = 4'd0;
			3'd1:    s = 4'd3;
			3'd2:    s = 4'd5;
			3'd3:    s = 4'd6;
			3'd4:    s = 4'd7;
			3'd5:    s = 4'd8;
			default: s = 4'd10;
		endcase
		return s;
	endfunction

endpackage

/* sv/timed_tone_prescale_select_core.sv */
// Top level of the timed tone prescale select block: sequencer, timer state and
// response register. Depends on ttps_pkg and ttps_divider.
`timescale 1ns / 1ps

// The block takes request beats on the req channel (req_valid, req_stall, req) and
// returns exactly one response beat per request on the rsp channel (rsp_valid,
// rsp_stall, rsp). The response shows the tone state after the request.
//
// A start request with a nonzero frequency runs one serial division,
// CLOCK_HZ / (2 * freq), one quotient bit per cycle. Every prescale divisor is a
// power of two, so the quotient for each divisor is that one quotient shifted
// right; the first one in 1..256 is picked combinationally after the division.
// Stop requests, zero-frequency starts, ticks and the unused code are answered
// on the cycle after acceptance.
//
// One request is in flight at a time: req_stall is high while a division is
// running, while the result waits to be written, and while a finished response
// is held by a stalled receiver. The response register keeps its beat stable
// until it is taken. Reset clears the millisecond clock, the stop time and the
// tone state, and leaves no response pending.
module timed_tone_prescale_select_core import ttps_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  ttps_req_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output ttps_rsp_t rsp
);

	ttps_state_t state_q, state_d;

	logic [31:0] now_q, now_d;
	logic [31:0] stop_q, stop_d;
	logic        active_q, active_d;
	logic [2:0]  csel_q, csel_d;
	logic [7:0]  match_q, match_d;

	logic        rsp_valid_q;
	ttps_rsp_t   rsp_q;

	logic        accept;
	logic        rsp_free;
	logic        is_tone;
	logic        div_start;
	logic        rsp_load;
	logic        div_done;
	logic [QUO_W-1:0] quotient;
	logic [31:0] now_inc;

	logic [2:0]  pick_code;
	logic [7:0]  pick_cmp;

	// The response register is free when empty or when its beat leaves this cycle.
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE) || !rsp_free;
	assign accept    = req_valid && !req_stall;
	assign is_tone   = (req.req_type == REQ_START) && (req.freq_hz != 16'd0);
	assign now_inc   = now_q + 32'd1;

	ttps_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  ({req.freq_hz, 1'b0}),
		.done     (div_done),
		.quotient (quotient)
	);

	// Prescale search. Scanning from the largest divisor down lets the smallest
	// fitting divisor win. When none fits, the slowest code with compare zero stays.
	always_comb begin
		logic [QUO_W-1:0] q_k;
		logic [QUO_W-1:0] q_m1;
		pick_code = CODE_SLOWEST;
		pick_cmp  = 8'd0;
		for (int k = NUM_DIV - 1; k >= 0; k--) begin
			q_k  = quotient >> div_shift(3'(k));
			q_m1 = q_k - QUO_W'(1);
			if (q_k != '0 && q_k <= QUO_W'(256)) begin
				pick_code = 3'(k + 1);
				pick_cmp  = q_m1[7:0];
			end
		end
	end

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (div_start) state_d = ST_DIVIDE;
			ST_DIVIDE: if (div_done) state_d = ST_WRITE;
			ST_WRITE:  if (rsp_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: start the divider, load the response register.
	always_comb begin
		div_start = 1'b0;
		rsp_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				div_start = accept && is_tone;
				rsp_load  = accept && !is_tone;
			end
			ST_DIVIDE: begin
				div_start = 1'b0;
				rsp_load  = 1'b0;
			end
			ST_WRITE: begin
				rsp_load = rsp_free;
			end
			default: begin
				div_start = 1'b0;
				rsp_load  = 1'b0;
			end
		endcase
	end

	// Timer and tone state updates.
	always_comb begin
		now_d    = now_q;
		stop_d   = stop_q;
		active_d = active_q;
		csel_d   = csel_q;
		match_d  = match_q;
		if (accept) begin
			case (req.req_type)
				REQ_START: begin
					if (is_tone) begin
						// The stop time is fixed now; the clock cannot move during the division.
						stop_d = now_q + {16'd0, req.tone_ms};
					end else begin
						active_d = 1'b0;
						csel_d   = CODE_OFF;
					end
				end
				REQ_STOP: begin
					active_d = 1'b0;
					csel_d   = CODE_OFF;
				end
				REQ_TICK: begin
					now_d = now_inc;
					// Plain unsigned compare; a wrap of the clock is not handled.
					if (active_q && now_inc >= stop_q) begin
						active_d = 1'b0;
						csel_d   = CODE_OFF;
					end
				end
				default: ;
			endcase
		end
		if (state_q == ST_DIVIDE && div_done) begin
			active_d = 1'b1;
			csel_d   = pick_code;
			match_d  = pick_cmp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			now_q       <= '0;
			stop_q      <= '0;
			active_q    <= 1'b0;
			csel_q      <= CODE_OFF;
			match_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			now_q    <= now_d;
			stop_q   <= stop_d;
			active_q <= active_d;
			csel_q   <= csel_d;
			match_q  <= match_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.sounding      <= active_d;
			rsp_q.prescale_code <= csel_d;
			rsp_q.compare_value <= match_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* sv/ttps_divider.sv */
// Serial restoring divider: CLOCK_HZ divided by a 17-bit divisor, one quotient bit
// per cycle. Depends on ttps_pkg.
`timescale 1ns / 1ps

module ttps_divider import ttps_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [QUO_W-1:0] quotient
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] count_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [QUO_W-1:0] quo_q;

	logic [DVS_W:0]   trial;
	logic             fits;
	logic [DVS_W:0]   diff;

	// One step: shift the next dividend bit into the partial remainder and try a subtract.
	assign trial = {rem_q, quo_q[QUO_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= busy_q && !start && (count_q == CNT_W'(QUO_W - 1));
			if (start) begin
				busy_q  <= 1'b1;
				count_q <= '0;
			end else if (busy_q) begin
				count_q <= count_q + 1'b1;
				if (count_q == CNT_W'(QUO_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= CLOCK_VAL;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
